// ----- rtl/tlbd_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbd_pkg
// Shared types and constants for the two-level button debounce.
// ----------------------------------------------------------------------------
package tlbd_pkg;

  localparam int THRESHOLD_WIDTH_DEF = 16;
  localparam int FIRST_THRESHOLD_RST = 10;
  localparam int SECOND_THRESHOLD_RST = 100;

  localparam int CFG_INDEX_W = 2;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_THRESHOLD = 2'd1;

  // reported level codes
  localparam logic [1:0] PRESS_IDLE = 2'd0;
  localparam logic [1:0] PRESS_FIRST = 2'd1;
  localparam logic [1:0] PRESS_SECOND = 2'd2;

  typedef enum logic [2:0] {
    LVL_IDLE = 3'b001,
    LVL_ONE  = 3'b010,
    LVL_TWO  = 3'b100
  } level_state_t;

  typedef struct packed {
    logic released_second;
    logic released_first;
    logic reached_second;
    logic reached_first;
    logic [1:0] press_level;
  } result_t;

endpackage

// ----- rtl/two_level_button_debounce.sv -----
// ----------------------------------------------------------------------------
// two_level_button_debounce
// Counter debounce with long-press detection: idle / level one / level two.
// ----------------------------------------------------------------------------
// Timing: a result beat is registered and appears on the output in the cycle after its input beat.
// Throughput: one input beat per cycle; the output register alone sets it,
//   and the input stalls only while that register holds an untaken beat.
// Reset (rst, synchronous): level goes idle, hold count clears, thresholds
//   return to 10 and 100 (low THRESHOLD_WIDTH bits), output goes empty.
module two_level_button_debounce #(
  parameter int THRESHOLD_WIDTH = tlbd_pkg::THRESHOLD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [tlbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [THRESHOLD_WIDTH-1:0]       cfg_data,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tlbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] button_level, rest zero
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] press_level, [2] reached_first, [3] reached_second,
  // [4] released_first, [5] released_second, [7:6] zero
  output logic [tlbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import tlbd_pkg::*;

  localparam int CNT_W = THRESHOLD_WIDTH + 1;

  logic [THRESHOLD_WIDTH-1:0] first_threshold;
  logic [THRESHOLD_WIDTH-1:0] second_threshold;

  level_state_t   level_state, level_state_next;
  logic [CNT_W-1:0] hold_count, hold_count_next;
  logic [CNT_W-1:0] count_inc;

  result_t result, result_next;
  logic    in_fire;
  logic    pressed;

  // Output register frees up when empty or being drained this cycle.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pressed       = s_axis_tdata[0];

  // Saturating increment; the ceiling is out of reach for legal thresholds.
  assign count_inc = (&hold_count) ? hold_count : hold_count + CNT_W'(1);

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_threshold  <= THRESHOLD_WIDTH'(FIRST_THRESHOLD_RST);
      second_threshold <= THRESHOLD_WIDTH'(SECOND_THRESHOLD_RST);
    end else if (cfg_we) begin
      if (cfg_index == REG_FIRST_THRESHOLD) begin
        first_threshold <= cfg_data;
      end
      if (cfg_index == REG_SECOND_THRESHOLD) begin
        second_threshold <= cfg_data;
      end
    end
  end

  // Level update for one beat. The count keeps running from level one into
  // level two and freezes while at level two; any release clears it.
  always_comb begin
    level_state_next = level_state;
    hold_count_next  = hold_count;
    result_next      = '0;
    unique case (level_state)
      LVL_ONE: begin
        if (pressed) begin
          hold_count_next = count_inc;
          if (count_inc > {1'b0, second_threshold}) begin
            level_state_next           = LVL_TWO;
            result_next.reached_second = 1'b1;
          end
        end else begin
          hold_count_next            = '0;
          level_state_next           = LVL_IDLE;
          result_next.released_first = 1'b1;
        end
      end
      LVL_TWO: begin
        if (!pressed) begin
          hold_count_next             = '0;
          level_state_next            = LVL_IDLE;
          result_next.released_second = 1'b1;
        end
      end
      default: begin
        level_state_next = LVL_IDLE;
        if (pressed) begin
          hold_count_next = count_inc;
          if (count_inc > {1'b0, first_threshold}) begin
            level_state_next          = LVL_ONE;
            result_next.reached_first = 1'b1;
          end
        end else begin
          hold_count_next = '0;
        end
      end
    endcase

    unique case (level_state_next)
      LVL_ONE: result_next.press_level = PRESS_FIRST;
      LVL_TWO: result_next.press_level = PRESS_SECOND;
      default: result_next.press_level = PRESS_IDLE;
    endcase
  end

  // State and hold count advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_state <= LVL_IDLE;
      hold_count  <= '0;
    end else if (in_fire) begin
      level_state <= level_state_next;
      hold_count  <= hold_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(result);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0({result.reached_first, result.reached_second,
                                result.released_first, result.released_second}))
    else $error("more than one event pulse in a result beat");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && !pressed |=> hold_count == '0 && level_state == LVL_IDLE)
    else $error("release did not clear count and level");

  a_second_from_first: assert property (@(posedge clk) disable iff (rst)
    in_fire && level_state_next == LVL_TWO && level_state != LVL_TWO
      |-> level_state == LVL_ONE)
    else $error("level two entered without passing level one");

  a_pulse_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && result.reached_second |-> result.press_level == PRESS_SECOND)
    else $error("reached_second without level two reported");

endmodule

// ----- tb/debounce_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounce_checker
// Watches the config port and both streams of two_level_button_debounce.
// It runs its own copy of the hold counter and level, queues one expected
// report per input beat, and compares every output beat with the oldest one.
// ----------------------------------------------------------------------------
module debounce_checker
  import tlbd_pkg::*;
#(
  parameter int THRESHOLD_WIDTH = THRESHOLD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [THRESHOLD_WIDTH-1:0] cfg_data,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [IN_TDATA_W-1:0]      s_axis_tdata,   // [0] button_level
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] press_level, [2] reached_first, [3] reached_second,
  // [4] released_first, [5] released_second
  input  logic [OUT_TDATA_W-1:0]     m_axis_tdata,
  output int                         reports_due,
  output int                         mismatch_count
);

  logic [THRESHOLD_WIDTH-1:0] first_thr;
  logic [THRESHOLD_WIDTH-1:0] second_thr;
  level_state_t               level;
  logic [THRESHOLD_WIDTH:0]   hold_cnt;
  result_t                    level_reports[$];
  int                         fails = 0;
  int                         due = 0;

  assign reports_due    = due;
  assign mismatch_count = fails;

  // One tick of the debouncer; updates the local level and counter.
  function automatic result_t next_level_report(input logic pressed);
    result_t r;
    r = '0;
    case (level)
      LVL_ONE: begin
        if (pressed) begin
          if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
          if (hold_cnt > {1'b0, second_thr}) begin
            level = LVL_TWO;
            r.reached_second = 1'b1;
          end
        end else begin
          hold_cnt = '0;
          level = LVL_IDLE;
          r.released_first = 1'b1;
        end
      end
      LVL_TWO: begin
        // counter frozen while held at level two
        if (!pressed) begin
          hold_cnt = '0;
          level = LVL_IDLE;
          r.released_second = 1'b1;
        end
      end
      default: begin
        level = LVL_IDLE;
        if (pressed) begin
          if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
          if (hold_cnt > {1'b0, first_thr}) begin
            level = LVL_ONE;
            r.reached_first = 1'b1;
          end
        end else begin
          hold_cnt = '0;
        end
      end
    endcase
    case (level)
      LVL_ONE: r.press_level = PRESS_FIRST;
      LVL_TWO: r.press_level = PRESS_SECOND;
      default: r.press_level = PRESS_IDLE;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      first_thr  = THRESHOLD_WIDTH'(FIRST_THRESHOLD_RST);
      second_thr = THRESHOLD_WIDTH'(SECOND_THRESHOLD_RST);
      level      = LVL_IDLE;
      hold_cnt   = '0;
      level_reports.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (level_reports.size() == 0) begin
          $error("result beat 0x%0h with no report pending", m_axis_tdata);
          fails++;
        end else begin
          want = level_reports.pop_front();
          check_field("press_level", int'(want.press_level), int'(got.press_level));
          check_field("reached_first", int'(want.reached_first),
                      int'(got.reached_first));
          check_field("reached_second", int'(want.reached_second),
                      int'(got.reached_second));
          check_field("released_first", int'(want.released_first),
                      int'(got.released_first));
          check_field("released_second", int'(want.released_second),
                      int'(got.released_second));
          check_field("tdata padding", 0,
                      int'(m_axis_tdata[OUT_TDATA_W-1:$bits(result_t)]));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_FIRST_THRESHOLD) first_thr = cfg_data;
        else if (cfg_index == REG_SECOND_THRESHOLD) second_thr = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        level_reports.push_back(next_level_report(s_axis_tdata[0]));
    end
    due = level_reports.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for two_level_button_debounce.
// A short directed sequence walks every level transition, release case and
// threshold extreme; random phases then send press runs sized around the
// current thresholds, with random gaps on both streams. debounce_checker
// does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import tlbd_pkg::*;

  localparam int TW              = THRESHOLD_WIDTH_DEF;
  localparam int STALL_LIMIT     = 2000;  // cycles with no beat on either side
  localparam int RANDOM_PHASES   = 12;
  localparam int BEATS_PER_PHASE = 152;
  localparam int MAX_RUN         = 240;   // cap on one press run
  localparam logic [TW-1:0] THR_MAX = '1;
  // index past the two registers; the block must ignore it
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd2;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FIRST_THRESHOLD;
  logic [TW-1:0]          cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] button_level
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [1:0] press_level, [2] reached_first, [3] reached_second,
  // [4] released_first, [5] released_second, [7:6] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fails;
  int reports_due;
  bit calm = 1'b0;       // no idling on either side while set
  bit in_beat = 1'b0;    // input beat taken at the last rising edge
  int quiet_cycles = 0;
  int first_set = FIRST_THRESHOLD_RST;
  int second_set = SECOND_THRESHOLD_RST;

  always #5 clk = ~clk;

  two_level_button_debounce #(.THRESHOLD_WIDTH(TW)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  debounce_checker #(.THRESHOLD_WIDTH(TW)) checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .reports_due    (reports_due),
    .mismatch_count (fails)
  );

  // Beat tracking and watchdog. Sampled at the rising edge; the sender reads
  // in_beat at the following falling edge.
  always @(posedge clk) begin
    in_beat <= s_axis_tvalid && s_axis_tready;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("** two_level_button_debounce: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side backpressure: ready low ~37% of cycles unless calm.
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 37);
  end

  // One button sample; random idle cycles ahead of it, then hold until taken.
  task automatic send_sample(input logic pressed);
    while (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, pressed};
    do @(negedge clk); while (!in_beat);
  endtask

  // Samples from a bit pattern, bit 0 first.
  task automatic send_pattern(input int n, input logic [31:0] bits);
    for (int i = 0; i < n; i++) send_sample(bits[i]);
  endtask

  // Stop sending and wait for every report to come back; the extra wait after
  // that leaves the block idle for config writes.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (reports_due != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [TW-1:0] first, input logic [TW-1:0] second);
    write_reg(REG_FIRST_THRESHOLD, first);
    write_reg(REG_SECOND_THRESHOLD, second);
    cfg_we <= 1'b0;
    first_set  = int'(first);
    second_set = int'(second);
  endtask

  // Mostly a clean press run sized around a threshold followed by a release,
  // sometimes a burst of random bounce.
  task automatic send_press_run(inout int left);
    int len;
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len && left > 0; i++) begin
        send_sample(1'($urandom_range(1)));
        left--;
      end
    end else begin
      if ($urandom_range(2) == 0) len = $urandom_range(0, first_set + 2);
      else len = $urandom_range(0, second_set + 4);
      if (len > MAX_RUN) len = $urandom_range(0, MAX_RUN);
      for (int i = 0; i < len && left > 0; i++) begin
        send_sample(1'b1);
        left--;
      end
      len = $urandom_range(1, 3);
      for (int i = 0; i < len && left > 0; i++) begin
        send_sample(1'b0);
        left--;
      end
    end
  endtask

  initial begin
    int left;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Zero first threshold: first press reaches level one, second press
    // level two, then a held tick, a release from two, a release from one,
    // and releases while idle.
    set_thresholds(0, 1);
    send_pattern(8, 32'b0010_1110);
    drain();

    // Second threshold below the count: level two right after level one.
    set_thresholds(3, 1);
    send_pattern(6, 32'b01_1111);
    drain();

    // Write to an unused index, then max thresholds; leave the button held
    // with a count of two.
    write_reg(REG_UNUSED, 16'hA5A5);
    set_thresholds(THR_MAX, THR_MAX);
    send_pattern(5, 32'b1_1011);
    drain();

    // Thresholds lowered mid-hold: the held count carries on against them.
    set_thresholds(2, 4);
    send_pattern(4, 32'b0111);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_thresholds(0, 0);
        1:       set_thresholds(THR_MAX, THR_MAX);
        2:       set_thresholds(TW'(FIRST_THRESHOLD_RST), TW'(SECOND_THRESHOLD_RST));
        3:       set_thresholds(0, THR_MAX);
        default: set_thresholds(TW'($urandom_range(0, 15)), TW'($urandom_range(0, 60)));
      endcase
      // a long stretch with no idling on either side
      calm <= (p == 4 || p == 5);
      left = BEATS_PER_PHASE;
      while (left > 0) send_press_run(left);
      drain();
    end

    if (fails == 0 && reports_due == 0) begin
      $display("** two_level_button_debounce: PASSED **");
    end else begin
      $display("** two_level_button_debounce: FAILED **");
    end
    $finish;
  end

endmodule
